/* rtl/orda_pkg.sv */
// Package: constants, register indexes and control types of the distance averager.
`timescale 1ns / 1ps
package orda_pkg;

  localparam int SAMPLES   = 5;
  localparam int IDX_W     = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int CNT_W     = $clog2(SAMPLES + 1);
  localparam int DIST_W    = 11;
  localparam int STORE_W   = 10;
  localparam int SUM_W     = 14;
  localparam int BOUND_W   = 11;
  localparam int KEPT_W    = 5;
  localparam int LIMIT_W   = 10;
  localparam int MARGIN_W  = 8;
  localparam int CFG_W     = 10;
  localparam int CFG_IDX_W = 1;
  localparam int DIV_CNT_W = $clog2(SUM_W);

  localparam logic [LIMIT_W-1:0]  LIMIT_RST  = LIMIT_W'(400);
  localparam logic [MARGIN_W-1:0] MARGIN_RST = MARGIN_W'(5);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VALID_LIMIT = 1'b0,
    REG_DEV_MARGIN  = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    DIV_MEAN = 2'd0,
    DIV_DEV  = 2'd1,
    DIV_KEPT = 2'd2
  } div_src_e;

  typedef struct packed {
    logic     accept;
    logic     clr_batch;
    logic     clr_scan;
    logic     dev_step;
    logic     keep_step;
    logic     div_start;
    div_src_e div_src;
    logic     ld_mean;
    logic     ld_bound;
    logic     ld_avg;
    logic     ld_none;
  } ctrl_cmd_t;

  typedef struct packed {
    logic last_pos;
    logic count_zero;
    logic kept_zero;
    logic scan_last;
    logic div_done;
    logic out_valid;
  } dp_status_t;

endpackage

/* rtl/orda_if.sv */
// Stream interfaces: sample channel and result channel.
`timescale 1ns / 1ps
interface orda_sample_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [orda_pkg::DIST_W-1:0]     sample_distance;

  modport source (output valid, output sample_distance, input ready);
  modport sink   (input valid, input sample_distance, output ready);
endinterface

interface orda_result_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [orda_pkg::DIST_W-1:0]     filtered_distance;
  logic        [orda_pkg::KEPT_W-1:0]     kept_count;

  modport source (output valid, output filtered_distance, output kept_count, input ready);
  modport sink   (input valid, input filtered_distance, input kept_count, output ready);
endinterface

/* rtl/orda_div.sv */
// Iterative restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps
module orda_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [orda_pkg::SUM_W-1:0]  dividend_i,
  input  logic [orda_pkg::CNT_W-1:0]  divisor_i,
  output logic [orda_pkg::SUM_W-1:0]  quotient_o,
  output logic                        done_o
);

  logic [orda_pkg::CNT_W-1:0]     rem_q, rem_d;
  logic [orda_pkg::SUM_W-1:0]     quo_q, quo_d;
  logic [orda_pkg::CNT_W-1:0]     dvs_q, dvs_d;
  logic [orda_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                           busy_q, busy_d;
  logic                           done_q, done_d;
  logic [orda_pkg::CNT_W:0]       trial;
  logic [orda_pkg::CNT_W:0]       diff;
  logic                           ge;

  always_comb begin
    trial = {rem_q, quo_q[orda_pkg::SUM_W-1]};
    ge    = (trial >= {1'b0, dvs_q});
    diff  = trial - {1'b0, dvs_q};
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d = ge ? diff[orda_pkg::CNT_W-1:0] : trial[orda_pkg::CNT_W-1:0];
      quo_d = {quo_q[orda_pkg::SUM_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == orda_pkg::DIV_CNT_W'(orda_pkg::SUM_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign quotient_o = quo_q;
  assign done_o     = done_q;

  a_start_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider restarted while busy");
  a_done_after_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q && $past(busy_q)) else $error("done without a running division");

endmodule

/* rtl/orda_dp.sv */
// Datapath: config registers, sample store, batch sums, divider and result register.
`timescale 1ns / 1ps
module orda_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [orda_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [orda_pkg::CFG_W-1:0]          cfg_data_i,
  input  orda_pkg::ctrl_cmd_t                 cmd_i,
  output orda_pkg::dp_status_t                status_o,
  input  logic signed [orda_pkg::DIST_W-1:0]  sample_distance_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic signed [orda_pkg::DIST_W-1:0]  filtered_distance_o,
  output logic [orda_pkg::KEPT_W-1:0]         kept_count_o
);

  logic [orda_pkg::LIMIT_W-1:0]  limit_q;
  logic [orda_pkg::MARGIN_W-1:0] margin_q;
  logic [orda_pkg::STORE_W-1:0]  store_q [orda_pkg::SAMPLES];
  logic [orda_pkg::CNT_W-1:0]    count_q, pos_q, idx_q, kept_q;
  logic [orda_pkg::SUM_W-1:0]    sum_q, dev_sum_q, kept_sum_q;
  logic [orda_pkg::STORE_W-1:0]  mean_q;
  logic [orda_pkg::BOUND_W-1:0]  bound_q;
  logic signed [orda_pkg::DIST_W-1:0] res_dist_q;
  logic [orda_pkg::KEPT_W-1:0]   res_kept_q;
  logic                          out_valid_q;

  logic                          sample_ok;
  logic [orda_pkg::STORE_W-1:0]  cur, absdiff;
  logic                          in_bound;
  logic [orda_pkg::SUM_W-1:0]    div_dividend, quotient;
  logic [orda_pkg::CNT_W-1:0]    div_divisor;
  logic                          div_done;

  assign sample_ok = !sample_distance_i[orda_pkg::DIST_W-1]
                  && (sample_distance_i != '0)
                  && (sample_distance_i[orda_pkg::STORE_W-1:0] < limit_q)
                  && (count_q < orda_pkg::CNT_W'(orda_pkg::SAMPLES));

  assign cur      = store_q[idx_q[orda_pkg::IDX_W-1:0]];
  assign absdiff  = (cur > mean_q) ? (cur - mean_q) : (mean_q - cur);
  assign in_bound = ({1'b0, absdiff} < bound_q);

  always_comb begin
    unique case (cmd_i.div_src)
      orda_pkg::DIV_MEAN: begin
        div_dividend = sum_q;
        div_divisor  = count_q;
      end
      orda_pkg::DIV_DEV: begin
        div_dividend = dev_sum_q;
        div_divisor  = count_q;
      end
      default: begin
        div_dividend = kept_sum_q;
        div_divisor  = kept_q;
      end
    endcase
  end

  orda_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quotient_o (quotient),
    .done_o     (div_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q  <= orda_pkg::LIMIT_RST;
      margin_q <= orda_pkg::MARGIN_RST;
    end else if (cfg_we_i) begin
      unique case (orda_pkg::cfg_idx_e'(cfg_idx_i))
        orda_pkg::REG_VALID_LIMIT: limit_q  <= cfg_data_i[orda_pkg::LIMIT_W-1:0];
        orda_pkg::REG_DEV_MARGIN:  margin_q <= cfg_data_i[orda_pkg::MARGIN_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      pos_q       <= '0;
      sum_q       <= '0;
      idx_q       <= '0;
      kept_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.clr_batch) begin
        count_q <= '0;
        pos_q   <= '0;
        sum_q   <= '0;
      end else if (cmd_i.accept) begin
        pos_q <= pos_q + 1'b1;
        if (sample_ok) begin
          count_q <= count_q + 1'b1;
          sum_q   <= sum_q + orda_pkg::SUM_W'(sample_distance_i[orda_pkg::STORE_W-1:0]);
        end
      end
      if (cmd_i.clr_scan) begin
        idx_q  <= '0;
        kept_q <= '0;
      end else if (cmd_i.dev_step) begin
        idx_q <= idx_q + 1'b1;
      end else if (cmd_i.keep_step) begin
        idx_q <= idx_q + 1'b1;
        if (in_bound) begin
          kept_q <= kept_q + 1'b1;
        end
      end
      if (cmd_i.ld_avg || cmd_i.ld_none) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept && sample_ok) begin
      store_q[count_q[orda_pkg::IDX_W-1:0]] <= sample_distance_i[orda_pkg::STORE_W-1:0];
    end
    if (cmd_i.clr_scan) begin
      dev_sum_q  <= '0;
      kept_sum_q <= '0;
    end else if (cmd_i.dev_step) begin
      dev_sum_q <= dev_sum_q + orda_pkg::SUM_W'(absdiff);
    end else if (cmd_i.keep_step && in_bound) begin
      kept_sum_q <= kept_sum_q + orda_pkg::SUM_W'(cur);
    end
    if (cmd_i.ld_mean) begin
      mean_q <= quotient[orda_pkg::STORE_W-1:0];
    end
    if (cmd_i.ld_bound) begin
      bound_q <= {1'b0, quotient[orda_pkg::STORE_W-1:0]} + orda_pkg::BOUND_W'(margin_q);
    end
    if (cmd_i.ld_avg) begin
      res_dist_q <= {1'b0, quotient[orda_pkg::STORE_W-1:0]};
      res_kept_q <= orda_pkg::KEPT_W'(kept_q);
    end else if (cmd_i.ld_none) begin
      res_dist_q <= '1;
      res_kept_q <= '0;
    end
  end

  always_comb begin
    status_o.last_pos   = (pos_q == orda_pkg::CNT_W'(orda_pkg::SAMPLES - 1));
    status_o.count_zero = (count_q == '0);
    status_o.kept_zero  = (kept_q == '0);
    status_o.scan_last  = (idx_q == count_q - 1'b1);
    status_o.div_done   = div_done;
    status_o.out_valid  = out_valid_q;
  end

  assign out_valid_o         = out_valid_q;
  assign filtered_distance_o = res_dist_q;
  assign kept_count_o        = res_kept_q;

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.ld_avg || cmd_i.ld_none) |-> !out_valid_q)
    else $error("result register overwritten before transfer");
  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q <= orda_pkg::CNT_W'(orda_pkg::SAMPLES)) && (count_q <= pos_q))
    else $error("valid count out of range");

endmodule

/* rtl/orda_ctrl.sv */
// Controller: batch collection and the finish sequence of the averager.
`timescale 1ns / 1ps
module orda_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  orda_pkg::dp_status_t status_i,
  output orda_pkg::ctrl_cmd_t  cmd_o
);

  typedef enum logic [7:0] {
    ST_IDLE    = 8'b0000_0001,
    ST_CHECK   = 8'b0000_0010,
    ST_MEAN    = 8'b0000_0100,
    ST_DEV     = 8'b0000_1000,
    ST_DEVGO   = 8'b0001_0000,
    ST_DEVDIV  = 8'b0010_0000,
    ST_KEEP    = 8'b0100_0000,
    ST_KEEPDIV = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   ready;
  logic   kick_q, kick_d;

  assign ready      = (state_q == ST_IDLE) && !(status_i.last_pos && status_i.out_valid);
  assign in_ready_o = ready;

  always_comb begin
    state_d       = state_q;
    cmd_o         = '0;
    cmd_o.div_src = orda_pkg::DIV_MEAN;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.accept = in_valid_i && ready;
        if (cmd_o.accept && status_i.last_pos) begin
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (status_i.count_zero) begin
          cmd_o.ld_none   = 1'b1;
          cmd_o.clr_batch = 1'b1;
          state_d         = ST_IDLE;
        end else begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_MEAN;
        end
      end
      ST_MEAN: begin
        if (status_i.div_done) begin
          cmd_o.ld_mean  = 1'b1;
          cmd_o.clr_scan = 1'b1;
          state_d        = ST_DEV;
        end
      end
      ST_DEV: begin
        cmd_o.dev_step = 1'b1;
        if (status_i.scan_last) begin
          state_d = ST_DEVGO;
        end
      end
      ST_DEVGO: begin
        cmd_o.div_src   = orda_pkg::DIV_DEV;
        cmd_o.div_start = 1'b1;
        state_d         = ST_DEVDIV;
      end
      ST_DEVDIV: begin
        cmd_o.div_src = orda_pkg::DIV_DEV;
        if (status_i.div_done) begin
          cmd_o.ld_bound = 1'b1;
          cmd_o.clr_scan = 1'b1;
          state_d        = ST_KEEP;
        end
      end
      ST_KEEP: begin
        cmd_o.keep_step = 1'b1;
        if (status_i.scan_last) begin
          state_d = ST_KEEPDIV;
        end
      end
      ST_KEEPDIV: begin
        cmd_o.div_src = orda_pkg::DIV_KEPT;
        if (kick_q) begin
          if (status_i.kept_zero) begin
            cmd_o.ld_none   = 1'b1;
            cmd_o.clr_batch = 1'b1;
            state_d         = ST_IDLE;
          end else begin
            cmd_o.div_start = 1'b1;
          end
        end else if (status_i.div_done) begin
          cmd_o.ld_avg    = 1'b1;
          cmd_o.clr_batch = 1'b1;
          state_d         = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // the kept-sample division starts in the cycle after the last scan step, or finishes empty
  always_comb begin
    kick_d = (state_q == ST_KEEP) && status_i.scan_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      kick_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      kick_q  <= kick_d;
    end
  end

  a_kick_in_keepdiv : assert property (@(posedge clk_i) disable iff (!rst_ni)
    kick_q |-> state_q == ST_KEEPDIV) else $error("kept division launched out of sequence");

endmodule

/* rtl/outlier_rejecting_distance_average.sv */
// Top level of the outlier-rejecting distance averager.
//
//   channel   direction  handshake      payload
//   sample_i  in         valid/ready    sample_distance (11b signed)
//   result_o  out        valid/ready    filtered_distance (11b signed), kept_count (5b)
//   cfg       in         cfg_we_i       cfg_idx_i (1b), cfg_data_i (10b)
//
// Samples are accepted while idle; the last sample of a batch starts a finish pass
// that runs the 14-step shared divider for the mean, the mean deviation and the kept
// average, which with no valid sample or nothing kept gives way to the empty result.
// Reset sets valid_limit to 400, deviation_margin to 5 and empties the batch.
// A result waits in its output register; samples keep transferring until the
// last sample of the next batch, which waits until that result is taken.
`timescale 1ns / 1ps
module outlier_rejecting_distance_average (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [orda_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [orda_pkg::CFG_W-1:0]      cfg_data_i,
  orda_sample_if.sink                     sample_i,
  orda_result_if.source                   result_o
);

  orda_pkg::ctrl_cmd_t  cmd;
  orda_pkg::dp_status_t status;

  orda_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (sample_i.valid),
    .in_ready_o (sample_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  orda_dp u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .cmd_i               (cmd),
    .status_o            (status),
    .sample_distance_i   (sample_i.sample_distance),
    .out_ready_i         (result_o.ready),
    .out_valid_o         (result_o.valid),
    .filtered_distance_o (result_o.filtered_distance),
    .kept_count_o        (result_o.kept_count)
  );

endmodule

/* test/tb.sv */
// Testbench for the outlier-rejecting distance averager: directed and random batches.
`timescale 1ns / 1ps
module tb;

  localparam int FINISH_CYCLES  = 3 * orda_pkg::SUM_W + 2 * orda_pkg::SAMPLES + 4 + 30;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASES         = 8;
  localparam int PHASE_BATCHES  = 30;

  typedef struct {
    logic signed [orda_pkg::DIST_W-1:0] avg;
    logic        [orda_pkg::KEPT_W-1:0] kept;
  } avg_result_t;

  typedef logic signed [orda_pkg::DIST_W-1:0] batch_t [orda_pkg::SAMPLES];

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic                           cfg_we_i;
  logic [orda_pkg::CFG_IDX_W-1:0] cfg_idx_i;
  logic [orda_pkg::CFG_W-1:0]     cfg_data_i;

  orda_sample_if smp ();
  orda_result_if res ();

  outlier_rejecting_distance_average u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .sample_i   (smp),
    .result_o   (res)
  );

  // predictor state
  logic [orda_pkg::STORE_W-1:0]  held_samples [orda_pkg::SAMPLES];
  int unsigned                   held_count;
  int unsigned                   held_sum;
  int unsigned                   batch_pos;
  logic [orda_pkg::LIMIT_W-1:0]  limit_reg;
  logic [orda_pkg::MARGIN_W-1:0] margin_reg;

  avg_result_t pending_averages [$];

  bit idle_on = 1'b1;
  int mismatches;
  int results_seen;
  int empty_results;
  int samples_sent;
  int settings_used;
  int idle_cycles;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((smp.valid && smp.ready) || (res.valid && res.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  task automatic flag_mismatch(input string what);
    if (mismatches < 50) $display("mismatch at %0t: %s", $time, what);
    mismatches++;
  endtask

  task automatic close_batch();
    int unsigned mean, dev_sum, dev_mean, bound, kept, kept_sum, diff;
    avg_result_t r;
    r.avg  = -11'sd1;
    r.kept = '0;
    if (held_count != 0) begin
      mean = held_sum / held_count;
      dev_sum = 0;
      for (int i = 0; i < held_count; i++) begin
        diff = (held_samples[i] > mean) ? held_samples[i] - mean : mean - held_samples[i];
        dev_sum += diff;
      end
      dev_mean = dev_sum / held_count;
      bound = dev_mean + margin_reg;
      kept = 0;
      kept_sum = 0;
      for (int i = 0; i < held_count; i++) begin
        diff = (held_samples[i] > mean) ? held_samples[i] - mean : mean - held_samples[i];
        if (diff < bound) begin
          kept_sum += held_samples[i];
          kept++;
        end
      end
      if (kept != 0) begin
        r.avg  = orda_pkg::DIST_W'(kept_sum / kept);
        r.kept = orda_pkg::KEPT_W'(kept);
      end
    end
    pending_averages.push_back(r);
    held_count = 0;
    held_sum = 0;
    batch_pos = 0;
  endtask

  task automatic predict_sample(input logic signed [orda_pkg::DIST_W-1:0] d);
    int v;
    v = d;
    if (v > 0 && v < int'(limit_reg) && held_count < orda_pkg::SAMPLES) begin
      held_samples[held_count] = orda_pkg::STORE_W'(v);
      held_count++;
      held_sum = (held_sum + v) & ((1 << orda_pkg::SUM_W) - 1);
    end
    batch_pos++;
    if (batch_pos == orda_pkg::SAMPLES) close_batch();
  endtask

  task automatic push_sample(input logic signed [orda_pkg::DIST_W-1:0] d);
    int gap;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      smp.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    smp.valid <= 1'b1;
    smp.sample_distance <= d;
    do @(posedge clk_i); while (!smp.ready);
    predict_sample(d);
    samples_sent++;
  endtask

  task automatic send_batch(input batch_t b);
    foreach (b[i]) push_sample(b[i]);
  endtask

  // sender holds off until every pending result is back and the finish pass is over
  task automatic drain_results();
    smp.valid <= 1'b0;
    while (pending_averages.size() != 0) @(posedge clk_i);
    repeat (FINISH_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_regs(input int unsigned lim, input int unsigned margin);
    drain_results();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= orda_pkg::REG_VALID_LIMIT;
    cfg_data_i <= orda_pkg::CFG_W'(lim);
    @(posedge clk_i);
    cfg_idx_i  <= orda_pkg::REG_DEV_MARGIN;
    cfg_data_i <= orda_pkg::CFG_W'(margin & 8'hFF);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    limit_reg  = orda_pkg::LIMIT_W'(lim);
    margin_reg = orda_pkg::MARGIN_W'(margin);
    settings_used++;
  endtask

  initial begin : result_check
    int stall;
    avg_result_t exp_r;
    res.ready <= 1'b0;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      stall = idle_on ? $urandom_range(0, 3) : 0;
      if (stall > 0) begin
        res.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      res.ready <= 1'b1;
      do @(posedge clk_i); while (!res.valid);
      results_seen++;
      if (pending_averages.size() == 0) begin
        flag_mismatch($sformatf("unexpected result %0d/%0d",
                                res.filtered_distance, res.kept_count));
      end else begin
        exp_r = pending_averages.pop_front();
        if (exp_r.kept == 0) empty_results++;
        if (res.filtered_distance !== exp_r.avg || res.kept_count !== exp_r.kept)
          flag_mismatch($sformatf("distance %0d kept %0d, expected %0d kept %0d",
                                  res.filtered_distance, res.kept_count,
                                  exp_r.avg, exp_r.kept));
      end
    end
  end

  task automatic test_reset_defaults();
    send_batch('{11'sd100, 11'sd102, 11'sd98, 11'sd130, 11'sd500});
  endtask

  task automatic test_range_edges();
    send_batch('{11'sd399, 11'sd400, 11'sd0, -11'sd1024, 11'sd1023});
    send_batch('{-11'sd1, -11'sd1, -11'sd1, -11'sd1, -11'sd1});
  endtask

  task automatic test_margin_zero();
    set_regs(1023, 0);
    send_batch('{11'sd10, 11'sd20, -11'sd1, 11'sd0, 11'sd1023});
  endtask

  task automatic test_limit_zero();
    set_regs(0, 255);
    send_batch('{11'sd1, 11'sd50, 11'sd1022, -11'sd1, 11'sd517});
  endtask

  task automatic test_extremes();
    set_regs(1023, 255);
    send_batch('{11'sd1022, 11'sd1022, 11'sd1022, 11'sd1022, 11'sd1});
  endtask

  function automatic logic signed [orda_pkg::DIST_W-1:0] pick_sample(input int center,
                                                                     input int jit);
    int mode;
    mode = $urandom_range(0, 99);
    if (mode < 60) return orda_pkg::DIST_W'(center + $urandom_range(0, 2 * jit) - jit);
    if (mode < 70) return orda_pkg::DIST_W'($urandom_range(1, 517));
    if (mode < 80) return -11'sd1;
    if (mode < 90) return orda_pkg::DIST_W'($urandom);
    return orda_pkg::DIST_W'(int'(limit_reg) + $urandom_range(0, 2) - 1);
  endfunction

  task automatic test_random_batches();
    int lim, margin, hi, center, jit;
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin lim = 1023; margin = 255; end
        1: begin lim = 1;    margin = 0;   end
        2: begin lim = 400;  margin = 5;   end
        default: begin
          lim = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 1023) : $urandom_range(250, 600);
          margin = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 20);
        end
      endcase
      set_regs(lim, margin);
      idle_on = (p % 3 != 1);
      hi = (lim > 518) ? 517 : ((lim > 1) ? lim - 1 : 1);
      for (int b = 0; b < PHASE_BATCHES; b++) begin
        center = $urandom_range(1, hi);
        jit = $urandom_range(0, 15);
        for (int i = 0; i < orda_pkg::SAMPLES; i++) push_sample(pick_sample(center, jit));
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    cfg_we_i            <= 1'b0;
    cfg_idx_i           <= orda_pkg::REG_VALID_LIMIT;
    cfg_data_i          <= '0;
    smp.valid           <= 1'b0;
    smp.sample_distance <= '0;
    idle_cycles   = 0;
    mismatches    = 0;
    results_seen  = 0;
    empty_results = 0;
    samples_sent  = 0;
    settings_used = 1;
    held_count    = 0;
    held_sum      = 0;
    batch_pos     = 0;
    limit_reg     = orda_pkg::LIMIT_RST;
    margin_reg    = orda_pkg::MARGIN_RST;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_range_edges();
    test_margin_zero();
    test_limit_zero();
    test_extremes();
    test_random_batches();

    smp.valid <= 1'b0;
    while (pending_averages.size() != 0) @(posedge clk_i);
    repeat (FINISH_CYCLES) @(posedge clk_i);

    $display("covered %0d samples over %0d register settings", samples_sent, settings_used);
    $display("checked %0d batch averages, %0d of them with nothing kept",
             results_seen, empty_results);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/orda_pkg.sv
rtl/orda_if.sv
rtl/orda_div.sv
rtl/orda_dp.sv
rtl/orda_ctrl.sv
rtl/outlier_rejecting_distance_average.sv
test/tb.sv
